[rtl/vqdm_pkg.sv]
// ----------------------------------------------------------------------------
// vqdm_pkg
// Shared types and codes of the split virtqueue descriptor manager.
// ----------------------------------------------------------------------------
package vqdm_pkg;

  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 152;

  // input commands
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_USED = 2'd1;
  localparam logic [1:0] CMD_POP  = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_DESC  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // kind of result beat the datapath builds
  typedef enum logic [2:0] {
    EM_FAIL_FIRST,
    EM_FAIL_NEXT,
    EM_EMPTY,
    EM_LONG,
    EM_PUSH,
    EM_USED,
    EM_POP
  } em_e;

  typedef struct packed {
    logic capture;
    logic init_wr;
    logic cur_free;
    logic cur_link;
    logic cur_used;
    logic cur_cursor;
    logic cur_id;
    logic free_chain;
    logic alloc_done;
    logic qest_ld;
    logic emit;
    em_e  kind;
  } dp_cmd_t;

  typedef struct packed {
    logic       init_last;
    logic [1:0] cmd;
    logic       push_idle;
    logic       push_failed;
    logic       short_free;
    logic       ring_empty;
    logic       rd_next;
    logic       walk_cap;
    logic       need_hit;
    logic       last_entry;
    logic       out_busy;
  } dp_stat_t;

endpackage

[rtl/vqdm_dp.sv]
// ----------------------------------------------------------------------------
// vqdm_dp
// Datapath: descriptor table, rings, queue state and the result register.
// ----------------------------------------------------------------------------
module vqdm_dp import vqdm_pkg::*; #(
  parameter int unsigned QUEUE_SIZE = 256,
  parameter int unsigned MAX_CHAIN  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic [1:0]  in_command_i,
  input  logic [63:0] in_address_i,
  input  logic [31:0] in_length_i,
  input  logic        in_writable_i,
  input  logic [4:0]  in_count_i,
  input  logic [7:0]  in_used_head_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [1:0]  out_status_o,
  output logic [7:0]  out_index_o,
  output logic [63:0] out_address_o,
  output logic [31:0] out_length_o,
  output logic        out_writable_o,
  output logic [31:0] out_total_o,
  output logic [8:0]  out_free_o,
  output logic        out_last_o
);

  localparam int unsigned IW    = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1;
  localparam int unsigned FW    = $clog2(QUEUE_SIZE + 1);
  localparam int unsigned NW    = $clog2(MAX_CHAIN + 1);
  localparam int unsigned CW    = (FW > NW) ? FW : NW;
  localparam int unsigned RECIP = 65536 / QUEUE_SIZE;

  // item and walk registers
  logic [1:0]    cmd_q;
  logic [63:0]   addr_q;
  logic [31:0]   len_q;
  logic          wr_q;
  logic [4:0]    count_q;
  logic [7:0]    uhead_q;
  logic [IW-1:0] cur_q, id_q;
  logic [CW-1:0] wcnt_q, ecnt_q;
  logic [31:0]   total_q;
  logic [7:0]    qest_q;

  // queue state
  logic [IW-1:0] free_top_q, push_head_q, push_cursor_q, init_q;
  logic [FW-1:0] free_total_q;
  logic [15:0]   avail_idx_q, used_idx_q, lui_q;
  logic [IW-1:0] avail_slot_q, used_slot_q, lui_slot_q;
  logic [NW-1:0] push_left_q;
  logic          push_failed_q;

  // memories and their read registers
  logic [63:0]   d_addr_m  [QUEUE_SIZE];
  logic [31:0]   d_len_m   [QUEUE_SIZE];
  logic [1:0]    d_flags_m [QUEUE_SIZE];
  logic [IW-1:0] d_link_m  [QUEUE_SIZE];
  logic [IW-1:0] avail_m   [QUEUE_SIZE];
  logic [IW-1:0] uhead_m   [QUEUE_SIZE];
  logic [31:0]   ulen_m    [QUEUE_SIZE];
  logic [63:0]   rd_addr_q;
  logic [31:0]   rd_len_q;
  logic [1:0]    rd_flags_q;
  logic [IW-1:0] rd_link_q;
  logic [IW-1:0] ur_head_q;
  logic [31:0]   ur_len_q;

  // result register
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [7:0]  out_index_q;
  logic [63:0] out_address_q;
  logic [31:0] out_length_q;
  logic        out_writable_q;
  logic [31:0] out_total_q;
  logic [8:0]  out_free_q;
  logic        out_last_q;

  logic [NW-1:0] n_need;
  logic          push_last;
  logic [23:0]   qprod;
  logic [8:0]    rem9;
  logic [IW-1:0] used_h;
  logic [CW:0]   free_sum;
  logic [FW-1:0] free_sat;
  logic          link_we;
  logic [IW-1:0] link_wa, link_wd;
  logic          do_push, do_used;

  function automatic logic [IW-1:0] slot_inc(input logic [15:0] idx,
                                             input logic [IW-1:0] s);
    logic [IW-1:0] r;
    if (idx == 16'hFFFF || s == IW'(QUEUE_SIZE - 1)) r = '0;
    else r = s + IW'(1);
    return r;
  endfunction

  always_comb begin
    if (count_q == 5'd0) n_need = NW'(1);
    else if (32'(count_q) > MAX_CHAIN) n_need = NW'(MAX_CHAIN);
    else n_need = NW'(count_q);
  end

  assign push_last = (push_left_q == NW'(1));
  assign do_push   = cmd_i.emit && (cmd_i.kind == EM_PUSH);
  assign do_used   = cmd_i.emit && (cmd_i.kind == EM_USED);

  // used head modulo queue size: reciprocal estimate, then one correction
  assign qprod = 24'(uhead_q) * 24'(RECIP);
  always_comb begin
    rem9 = 9'(uhead_q) - 9'(32'(qest_q) * QUEUE_SIZE);
    if (13'(rem9) >= 13'(QUEUE_SIZE)) used_h = IW'(13'(rem9) - 13'(QUEUE_SIZE));
    else used_h = IW'(rem9);
  end

  always_comb begin
    free_sum = (CW + 1)'(wcnt_q) + (CW + 1)'(free_total_q);
    if (32'(free_sum) > QUEUE_SIZE) free_sat = FW'(QUEUE_SIZE);
    else free_sat = FW'(free_sum);
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = cur_q;
    link_wd = '0;
    if (cmd_i.init_wr) begin
      link_we = 1'b1;
      link_wa = init_q;
      link_wd = (init_q == IW'(QUEUE_SIZE - 1)) ? '0 : init_q + IW'(1);
    end else if (cmd_i.free_chain) begin
      link_we = 1'b1;
      link_wd = free_top_q;
    end else if (do_push && push_last) begin
      link_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) d_link_m[link_wa] <= link_wd;
    if (do_push) begin
      d_addr_m[cur_q]  <= addr_q;
      d_len_m[cur_q]   <= len_q;
      d_flags_m[cur_q] <= {wr_q, ~push_last};
    end
    if (do_push && push_last) avail_m[avail_slot_q] <= push_head_q;
    if (do_used) begin
      uhead_m[used_slot_q] <= used_h;
      ulen_m[used_slot_q]  <= len_q;
    end
    rd_addr_q  <= d_addr_m[cur_q];
    rd_len_q   <= d_len_m[cur_q];
    rd_flags_q <= d_flags_m[cur_q];
    rd_link_q  <= d_link_m[cur_q];
    ur_head_q  <= uhead_m[lui_slot_q];
    ur_len_q   <= ulen_m[lui_slot_q];
  end

  // item capture and chain walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= in_command_i;
      addr_q  <= in_address_i;
      len_q   <= in_length_i;
      wr_q    <= in_writable_i;
      count_q <= in_count_i;
      uhead_q <= in_used_head_i;
    end
    if (cmd_i.cur_free) begin
      cur_q  <= free_top_q;
      wcnt_q <= CW'(1);
    end
    if (cmd_i.cur_link) begin
      cur_q  <= rd_link_q;
      wcnt_q <= wcnt_q + CW'(1);
    end
    if (cmd_i.cur_used) begin
      cur_q   <= ur_head_q;
      id_q    <= ur_head_q;
      total_q <= ur_len_q;
      wcnt_q  <= CW'(1);
    end
    if (cmd_i.cur_cursor) cur_q <= push_cursor_q;
    if (cmd_i.cur_id) begin
      cur_q  <= id_q;
      wcnt_q <= CW'(1);
    end
    if (cmd_i.free_chain) ecnt_q <= wcnt_q;
    if (cmd_i.qest_ld) qest_q <= qprod[23:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q    <= '0;
      free_total_q  <= FW'(QUEUE_SIZE);
      avail_idx_q   <= '0;
      avail_slot_q  <= '0;
      used_idx_q    <= '0;
      used_slot_q   <= '0;
      lui_q         <= '0;
      lui_slot_q    <= '0;
      push_left_q   <= '0;
      push_head_q   <= '0;
      push_cursor_q <= '0;
      push_failed_q <= 1'b0;
      init_q        <= '0;
    end else begin
      if (cmd_i.init_wr) init_q <= init_q + IW'(1);
      if (cmd_i.free_chain) begin
        free_top_q   <= id_q;
        free_total_q <= free_sat;
        lui_q        <= lui_q + 16'd1;
        lui_slot_q   <= slot_inc(lui_q, lui_slot_q);
      end
      if (cmd_i.alloc_done) begin
        push_head_q   <= free_top_q;
        push_cursor_q <= free_top_q;
        free_top_q    <= rd_link_q;
        free_total_q  <= free_total_q - FW'(n_need);
        push_failed_q <= 1'b0;
        push_left_q   <= n_need;
      end
      if (cmd_i.emit) begin
        case (cmd_i.kind)
          EM_FAIL_FIRST: begin
            push_failed_q <= (n_need > NW'(1));
            push_left_q   <= n_need - NW'(1);
          end
          EM_FAIL_NEXT: begin
            push_left_q <= push_left_q - NW'(1);
            if (push_last) push_failed_q <= 1'b0;
          end
          EM_PUSH: begin
            push_left_q <= push_left_q - NW'(1);
            if (push_last) begin
              avail_idx_q  <= avail_idx_q + 16'd1;
              avail_slot_q <= slot_inc(avail_idx_q, avail_slot_q);
            end else begin
              push_cursor_q <= rd_link_q;
            end
          end
          EM_USED: begin
            used_idx_q  <= used_idx_q + 16'd1;
            used_slot_q <= slot_inc(used_idx_q, used_slot_q);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q   <= ST_OK;
      out_index_q    <= '0;
      out_address_q  <= '0;
      out_length_q   <= '0;
      out_writable_q <= 1'b0;
      out_total_q    <= '0;
      out_free_q     <= 9'(free_total_q);
      out_last_q     <= 1'b1;
      case (cmd_i.kind) inside
        EM_FAIL_FIRST, EM_FAIL_NEXT: out_status_q <= ST_NO_DESC;
        EM_EMPTY:                    out_status_q <= ST_EMPTY;
        EM_LONG:                     out_status_q <= ST_TOO_LONG;
        EM_PUSH:                     out_index_q  <= 8'(cur_q);
        EM_USED:                     out_index_q  <= 8'(used_h);
        EM_POP: begin
          out_index_q    <= 8'(cur_q);
          out_address_q  <= rd_addr_q;
          out_length_q   <= rd_len_q;
          out_writable_q <= rd_flags_q[1];
          out_total_q    <= total_q;
          out_last_q     <= (wcnt_q == ecnt_q);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o.init_last   = (init_q == IW'(QUEUE_SIZE - 1));
    stat_o.cmd         = cmd_q;
    stat_o.push_idle   = (push_left_q == '0);
    stat_o.push_failed = push_failed_q;
    stat_o.short_free  = (32'(n_need) > 32'(free_total_q));
    stat_o.ring_empty  = (lui_q == used_idx_q);
    stat_o.rd_next     = rd_flags_q[0];
    stat_o.walk_cap    = (32'(wcnt_q) >= QUEUE_SIZE);
    stat_o.need_hit    = (32'(wcnt_q) >= 32'(n_need));
    stat_o.last_entry  = (wcnt_q == ecnt_q);
    stat_o.out_busy    = out_valid_q && !out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_index_o    = out_index_q;
  assign out_address_o  = out_address_q;
  assign out_length_o   = out_length_q;
  assign out_writable_o = out_writable_q;
  assign out_total_o    = out_total_q;
  assign out_free_o     = out_free_q;
  assign out_last_o     = out_last_q;

endmodule

[rtl/vqdm_ctrl.sv]
// ----------------------------------------------------------------------------
// vqdm_ctrl
// Controller: sequences allocation, reclaim, push, used report and pop.
// ----------------------------------------------------------------------------
module vqdm_ctrl import vqdm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [4:0] S_INIT        = 5'd0;
  localparam logic [4:0] S_IDLE        = 5'd1;
  localparam logic [4:0] S_DECODE      = 5'd2;
  localparam logic [4:0] S_RECL_CHK    = 5'd3;
  localparam logic [4:0] S_RECL_HEAD   = 5'd4;
  localparam logic [4:0] S_RECL_WAIT   = 5'd5;
  localparam logic [4:0] S_RECL_STEP   = 5'd6;
  localparam logic [4:0] S_ALLOC_CHK   = 5'd7;
  localparam logic [4:0] S_ALLOC_START = 5'd8;
  localparam logic [4:0] S_ALLOC_WAIT  = 5'd9;
  localparam logic [4:0] S_ALLOC_STEP  = 5'd10;
  localparam logic [4:0] S_FAIL_FIRST  = 5'd11;
  localparam logic [4:0] S_FAIL_NEXT   = 5'd12;
  localparam logic [4:0] S_WR_SEEK     = 5'd13;
  localparam logic [4:0] S_WR_WAIT     = 5'd14;
  localparam logic [4:0] S_WR_EMIT     = 5'd15;
  localparam logic [4:0] S_USED_A      = 5'd16;
  localparam logic [4:0] S_USED_EMIT   = 5'd17;
  localparam logic [4:0] S_EMPTY       = 5'd18;
  localparam logic [4:0] S_POP_START   = 5'd19;
  localparam logic [4:0] S_POP_WAIT    = 5'd20;
  localparam logic [4:0] S_POP_STEP    = 5'd21;
  localparam logic [4:0] S_TOO_LONG    = 5'd22;
  localparam logic [4:0] S_EM_SEEK     = 5'd23;
  localparam logic [4:0] S_EM_WAIT     = 5'd24;
  localparam logic [4:0] S_EM_OUT      = 5'd25;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (stat_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          CMD_PUSH: begin
            if (!stat_i.push_idle) begin
              state_d = stat_i.push_failed ? S_FAIL_NEXT : S_WR_SEEK;
            end else begin
              state_d = stat_i.short_free ? S_RECL_CHK : S_ALLOC_START;
            end
          end
          CMD_USED: state_d = S_USED_A;
          CMD_POP:  state_d = stat_i.ring_empty ? S_EMPTY : S_POP_START;
          CMD_NONE: state_d = S_IDLE;
          default:  state_d = S_IDLE;
        endcase
      end
      // return every completed used chain to the free list
      S_RECL_CHK:  state_d = stat_i.ring_empty ? S_ALLOC_CHK : S_RECL_HEAD;
      S_RECL_HEAD: begin
        cmd_o.cur_used = 1'b1;
        state_d        = S_RECL_WAIT;
      end
      S_RECL_WAIT: state_d = S_RECL_STEP;
      S_RECL_STEP: begin
        if (stat_i.rd_next && !stat_i.walk_cap) begin
          cmd_o.cur_link = 1'b1;
          state_d        = S_RECL_WAIT;
        end else begin
          cmd_o.free_chain = 1'b1;
          state_d          = S_RECL_CHK;
        end
      end
      S_ALLOC_CHK: state_d = stat_i.short_free ? S_FAIL_FIRST : S_ALLOC_START;
      S_ALLOC_START: begin
        cmd_o.cur_free = 1'b1;
        state_d        = S_ALLOC_WAIT;
      end
      S_ALLOC_WAIT: state_d = S_ALLOC_STEP;
      S_ALLOC_STEP: begin
        if (stat_i.need_hit) begin
          cmd_o.alloc_done = 1'b1;
          state_d          = S_WR_SEEK;
        end else begin
          cmd_o.cur_link = 1'b1;
          state_d        = S_ALLOC_WAIT;
        end
      end
      S_FAIL_FIRST: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EM_FAIL_FIRST;
          state_d    = S_IDLE;
        end
      end
      S_FAIL_NEXT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EM_FAIL_NEXT;
          state_d    = S_IDLE;
        end
      end
      S_WR_SEEK: begin
        cmd_o.cur_cursor = 1'b1;
        state_d          = S_WR_WAIT;
      end
      S_WR_WAIT: state_d = S_WR_EMIT;
      S_WR_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EM_PUSH;
          state_d    = S_IDLE;
        end
      end
      S_USED_A: begin
        cmd_o.qest_ld = 1'b1;
        state_d       = S_USED_EMIT;
      end
      S_USED_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EM_USED;
          state_d    = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EM_EMPTY;
          state_d    = S_IDLE;
        end
      end
      // first pass: measure the chain against the pop capacity
      S_POP_START: begin
        cmd_o.cur_used = 1'b1;
        state_d        = S_POP_WAIT;
      end
      S_POP_WAIT: state_d = S_POP_STEP;
      S_POP_STEP: begin
        if (!stat_i.rd_next) begin
          cmd_o.free_chain = 1'b1;
          state_d          = S_EM_SEEK;
        end else if (stat_i.need_hit) begin
          state_d = S_TOO_LONG;
        end else begin
          cmd_o.cur_link = 1'b1;
          state_d        = S_POP_WAIT;
        end
      end
      S_TOO_LONG: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EM_LONG;
          state_d    = S_IDLE;
        end
      end
      // second pass: emit one beat per descriptor
      S_EM_SEEK: begin
        cmd_o.cur_id = 1'b1;
        state_d      = S_EM_WAIT;
      end
      S_EM_WAIT: state_d = S_EM_OUT;
      S_EM_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EM_POP;
          if (stat_i.last_entry) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.cur_link = 1'b1;
            state_d        = S_EM_WAIT;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[rtl/virtqueue_descriptor_manager_top.sv]
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager_top
// Driver side of a split virtqueue: free list, avail and used rings.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  s_axis   | in  | tuser: command; tdata: address, length, writable, count, head
//  m_axis   | out | tuser: status; tdata: index .. free; tlast: last of run
//
// The first entry of a chain walks the free list for the descriptors taken, and
// reclaim, when free descriptors fall short, first walks every used chain. A pop
// walks its chain twice through the registered descriptor table port. After
// reset a clearing pass builds the free list; a result waits in an output
// register and a stall holds the sequencer there.
module virtqueue_descriptor_manager_top import vqdm_pkg::*; #(
  parameter int unsigned QUEUE_SIZE = 256,
  parameter int unsigned MAX_CHAIN  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [63:0] buffer_address, [95:64] buffer_length, [96] dev_write,
  // [101:97] entry_count, [109:102] used_head
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]             s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [7:0] descriptor_index, [71:8] out_address, [103:72] out_length,
  // [104] out_writable, [136:105] used_total_length, [145:137] free_remaining
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]             m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [7:0]  o_index;
  logic [63:0] o_address;
  logic [31:0] o_length;
  logic        o_writable;
  logic [31:0] o_total;
  logic [8:0]  o_free;

  vqdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vqdm_dp #(
    .QUEUE_SIZE (QUEUE_SIZE),
    .MAX_CHAIN  (MAX_CHAIN)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_command_i   (s_axis_tuser_i),
    .in_address_i   (s_axis_tdata_i[63:0]),
    .in_length_i    (s_axis_tdata_i[95:64]),
    .in_writable_i  (s_axis_tdata_i[96]),
    .in_count_i     (s_axis_tdata_i[101:97]),
    .in_used_head_i (s_axis_tdata_i[109:102]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_status_o   (m_axis_tuser_o),
    .out_index_o    (o_index),
    .out_address_o  (o_address),
    .out_length_o   (o_length),
    .out_writable_o (o_writable),
    .out_total_o    (o_total),
    .out_free_o     (o_free),
    .out_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'd0, o_free, o_total, o_writable, o_length, o_address, o_index};

endmodule

[rtl/vqdm_chk.sv]
// ----------------------------------------------------------------------------
// vqdm_chk
// Port checker for the virtqueue descriptor manager, bound to the top level.
// ----------------------------------------------------------------------------
module vqdm_chk import vqdm_pkg::*; #(
  parameter int unsigned QUEUE_SIZE = 256
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic [1:0]             s_axis_tuser_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]             m_axis_tuser_o,
  input logic                   m_axis_tlast_o
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled result beat changed");

  // an error beat ends its run and carries no descriptor
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_OK |-> m_axis_tlast_o
      && m_axis_tdata_o[7:0] == 8'd0 && m_axis_tdata_o[104:8] == '0)
    else $error("error beat with payload or without last");

  // no new item while a pop run is still being delivered
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input taken in the middle of a pop run");

  // free count never exceeds the table
  a_free_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> 32'(m_axis_tdata_o[145:137]) <= QUEUE_SIZE)
    else $error("free count above queue size");

endmodule

bind virtqueue_descriptor_manager_top vqdm_chk #(.QUEUE_SIZE(QUEUE_SIZE)) u_vqdm_chk (.*);

[tb/virtqueue_descriptor_manager_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager_top_tb
// Stream-level test of the split virtqueue descriptor manager. A ring model in
// the testbench predicts every result beat while the stimulus is built; a
// clocked driver plays the commands with random gaps and a clocked monitor
// checks each beat, with random back-pressure, against the oldest prediction.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager_top_tb;
  import vqdm_pkg::*;

  localparam int unsigned QSIZE     = 256;
  localparam int unsigned CHAIN_MAX = 16;
  localparam int unsigned CYCLE_CAP = 1000000;

  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] addr;
    logic [31:0] len;
    logic        wr;
    logic [4:0]  cnt;
    logic [7:0]  head;
    bit          hold;
    int unsigned beats_before;
    bit          calm;
  } cmd_item_t;

  typedef struct {
    logic [1:0]  st;
    logic [7:0]  idx;
    logic [63:0] addr;
    logic [31:0] len;
    logic        wr;
    logic [31:0] total;
    logic [8:0]  free;
    logic        last;
  } ring_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic [1:0]             s_axis_tuser_i = CMD_NONE;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [1:0]             m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  virtqueue_descriptor_manager_top #(
    .QUEUE_SIZE(QSIZE),
    .MAX_CHAIN (CHAIN_MAX)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ring model state
  logic [63:0] d_addr [QSIZE];
  logic [31:0] d_len  [QSIZE];
  logic [1:0]  d_flag [QSIZE];
  logic [7:0]  d_link [QSIZE];
  logic [7:0]  used_hd [QSIZE];
  logic [31:0] used_ln [QSIZE];
  logic [7:0]  free_top;
  int unsigned free_cnt;
  logic [15:0] avail_idx, used_idx, seen_idx;
  int unsigned chain_left;
  logic [7:0]  chain_head, chain_cursor;
  bit          chain_failed;

  cmd_item_t    cmd_backlog[$];
  ring_result_t ring_results[$];
  logic [7:0]   ready_heads[$];
  int unsigned  beats_predicted = 0;
  int unsigned  beats_seen = 0;
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  bit           calm_mode = 1'b0;

  function automatic void note_result(logic [1:0] st, logic [7:0] idx, logic [63:0] addr,
                                      logic [31:0] len, logic wr, logic [31:0] total,
                                      logic last);
    ring_result_t r;
    r.st = st; r.idx = idx; r.addr = addr; r.len = len; r.wr = wr;
    r.total = total; r.free = free_cnt[8:0]; r.last = last;
    ring_results.push_back(r);
    beats_predicted++;
  endfunction

  function automatic int unsigned sat_count(logic [4:0] c);
    if (c == 0) return 1;
    if (c > CHAIN_MAX) return CHAIN_MAX;
    return 32'(c);
  endfunction

  function automatic void release_chain(logic [7:0] tail, logic [7:0] id, int unsigned n);
    d_link[tail] = free_top;
    free_top = id;
    free_cnt += n;
    if (free_cnt > QSIZE) free_cnt = QSIZE;
    seen_idx = seen_idx + 16'd1;
  endfunction

  function automatic void reclaim_used();
    logic [7:0] id, d;
    int unsigned n;
    while (seen_idx != used_idx) begin
      id = used_hd[seen_idx[7:0]];
      d = id;
      n = 1;
      while (d_flag[d][0] && n < QSIZE) begin
        d = d_link[d];
        n++;
      end
      release_chain(d, id, n);
    end
  endfunction

  function automatic void push_entry(cmd_item_t it);
    int unsigned n;
    logic [7:0] d;
    if (chain_left == 0) begin
      n = sat_count(it.cnt);
      if (n > free_cnt) reclaim_used();
      if (n > free_cnt) begin
        chain_failed = (n > 1);
        chain_left = n - 1;
        note_result(ST_NO_DESC, '0, '0, '0, 1'b0, '0, 1'b1);
        return;
      end
      chain_head = free_top;
      d = free_top;
      for (int i = 1; i < n; i++) d = d_link[d];
      free_top = d_link[d];
      free_cnt -= n;
      chain_failed = 1'b0;
      chain_left = n;
      chain_cursor = chain_head;
    end
    if (chain_failed) begin
      chain_left--;
      if (chain_left == 0) chain_failed = 1'b0;
      note_result(ST_NO_DESC, '0, '0, '0, 1'b0, '0, 1'b1);
      return;
    end
    d = chain_cursor;
    d_addr[d] = it.addr;
    d_len[d] = it.len;
    d_flag[d] = {it.wr, 1'b1};
    chain_left--;
    if (chain_left == 0) begin
      d_link[d] = '0;
      d_flag[d][0] = 1'b0;
      avail_idx = avail_idx + 16'd1;
      ready_heads.push_back(chain_head);
    end else begin
      chain_cursor = d_link[d];
    end
    note_result(ST_OK, d, '0, '0, 1'b0, '0, 1'b1);
  endfunction

  function automatic void pop_used(cmd_item_t it);
    logic [7:0] chain[CHAIN_MAX];
    int unsigned cap, n;
    logic [7:0] id, d;
    logic [31:0] total;
    if (seen_idx == used_idx) begin
      note_result(ST_EMPTY, '0, '0, '0, 1'b0, '0, 1'b1);
      return;
    end
    cap = sat_count(it.cnt);
    id = used_hd[seen_idx[7:0]];
    total = used_ln[seen_idx[7:0]];
    d = id;
    n = 0;
    forever begin
      chain[n] = d;
      n++;
      if (!d_flag[d][0]) break;
      if (n >= cap) begin
        note_result(ST_TOO_LONG, '0, '0, '0, 1'b0, '0, 1'b1);
        return;
      end
      d = d_link[d];
    end
    release_chain(d, id, n);
    for (int k = 0; k < n; k++)
      note_result(ST_OK, chain[k], d_addr[chain[k]], d_len[chain[k]], d_flag[chain[k]][1],
                  total, k + 1 == n);
  endfunction

  function automatic void advance_ring(cmd_item_t it);
    case (it.cmd)
      CMD_PUSH: push_entry(it);
      CMD_USED: begin
        used_hd[used_idx[7:0]] = it.head;
        used_ln[used_idx[7:0]] = it.len;
        used_idx = used_idx + 16'd1;
        note_result(ST_OK, it.head, '0, '0, 1'b0, '0, 1'b1);
      end
      CMD_POP: pop_used(it);
      default: ;
    endcase
  endfunction

  function automatic void queue_cmd(logic [1:0] cmd, logic [63:0] addr, logic [31:0] len,
                                    logic wr, logic [4:0] cnt, logic [7:0] head,
                                    bit hold, bit calm);
    cmd_item_t it;
    it.cmd = cmd; it.addr = addr; it.len = len; it.wr = wr; it.cnt = cnt;
    it.head = head; it.hold = hold; it.beats_before = beats_predicted; it.calm = calm;
    cmd_backlog.push_back(it);
    advance_ring(it);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // report a random completed chain; fall back to a pop when none is ready
  function automatic void queue_report(bit calm);
    int unsigned k;
    logic [7:0] h;
    if (ready_heads.size() == 0) begin
      queue_cmd(CMD_POP, rand64(), $urandom(), 1'($urandom_range(0, 1)),
                5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)), 1'b0, calm);
      return;
    end
    k = $urandom_range(0, ready_heads.size() - 1);
    h = ready_heads[k];
    ready_heads.delete(k);
    queue_cmd(CMD_USED, rand64(), $urandom(), 1'($urandom_range(0, 1)),
              5'($urandom_range(0, 31)), h, 1'b0, calm);
  endfunction

  function automatic void queue_random(bit calm, bit fill);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (fill || (chain_left > 0 && p < 75) || (chain_left == 0 && p < 40)) begin
      queue_cmd(CMD_PUSH, rand64(), $urandom(), 1'($urandom_range(0, 1)),
                fill ? 5'd16 : 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                1'b0, calm);
    end else if (p < 85) begin
      queue_report(calm);
    end else if (p < 97) begin
      queue_cmd(CMD_POP, rand64(), $urandom(), 1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 3))
                                            : 5'($urandom_range(0, 31)),
                8'($urandom_range(0, 255)), 1'b0, calm);
    end else begin
      queue_cmd(CMD_NONE, rand64(), $urandom(), 1'($urandom_range(0, 1)),
                5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)), 1'b0, calm);
    end
  endfunction

  initial begin
    for (int i = 0; i < QSIZE; i++) begin
      d_addr[i] = '0; d_len[i] = '0; d_flag[i] = '0;
      d_link[i] = (i + 1 == QSIZE) ? 8'd0 : 8'(i + 1);
      used_hd[i] = '0; used_ln[i] = '0;
    end
    free_top = '0; free_cnt = QSIZE;
    avail_idx = '0; used_idx = '0; seen_idx = '0;
    chain_left = 0; chain_head = '0; chain_cursor = '0; chain_failed = 1'b0;

    // directed: empty pop, unused command, count extremes, short pop capacity
    queue_cmd(CMD_POP, '0, '0, 1'b0, 5'd4, '0, 1'b0, 1'b0);
    queue_cmd(CMD_NONE, '1, '1, 1'b1, '1, '1, 1'b0, 1'b0);
    queue_cmd(CMD_PUSH, '1, '1, 1'b1, 5'd0, '0, 1'b0, 1'b0);
    queue_cmd(CMD_PUSH, '0, '0, 1'b0, 5'd31, '1, 1'b0, 1'b0);
    for (int i = 1; i < CHAIN_MAX; i++)
      queue_cmd(CMD_PUSH, rand64(), $urandom(), i[0], 5'd1, '0, 1'b0, 1'b0);
    queue_cmd(CMD_USED, '0, '1, 1'b0, 5'd1, ready_heads.pop_front(), 1'b0, 1'b0);
    queue_cmd(CMD_USED, '0, '0, 1'b0, 5'd1, ready_heads.pop_front(), 1'b0, 1'b0);
    queue_cmd(CMD_POP, '0, '0, 1'b0, 5'd1, '0, 1'b0, 1'b0);
    queue_cmd(CMD_POP, '0, '0, 1'b0, 5'd2, '0, 1'b0, 1'b0);
    queue_cmd(CMD_POP, '0, '0, 1'b0, 5'd31, '0, 1'b0, 1'b0);

    for (int i = 0; i < 30; i++) queue_random(1'b0, 1'b0);
    // finish any open chain, then drain before going on
    while (chain_left > 0) queue_random(1'b0, 1'b1);
    queue_cmd(CMD_POP, rand64(), $urandom(), 1'b1, 5'd16, '0, 1'b1, 1'b0);
    // fill the table until a chain runs out of descriptors
    while (free_cnt >= CHAIN_MAX || chain_left > 0 || seen_idx != used_idx)
      if (seen_idx != used_idx) queue_cmd(CMD_POP, '0, '0, 1'b0, 5'd16, '0, 1'b0, 1'b0);
      else queue_random(1'b0, 1'b1);
    for (int i = 0; i < CHAIN_MAX; i++) queue_random(1'b0, 1'b1);
    for (int i = 0; i < 10; i++) queue_random(1'b0, 1'b0);
    for (int i = 0; i < 15; i++) queue_random(1'b1, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (cmd_backlog.size() == 0 && beats_seen >= beats_predicted);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && ring_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // driver
  int unsigned send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_item_t it;
    logic v_next;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      v_next = s_axis_tvalid_i && !s_axis_tready_o;
      if (!v_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_backlog.size() > 0 &&
                     (!cmd_backlog[0].hold || beats_seen == cmd_backlog[0].beats_before)) begin
          it = cmd_backlog.pop_front();
          calm_mode = calm_mode | it.calm;
          s_axis_tuser_i <= it.cmd;
          s_axis_tdata_i <= {2'b0, it.head, it.cnt, it.wr, it.len, it.addr};
          v_next = 1'b1;
          if (!calm_mode && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 8);
        end
      end
      s_axis_tvalid_i <= v_next;
    end
  end

  // monitor
  int unsigned sink_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    ring_result_t x;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        beats_seen++;
        if (ring_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat tuser=%0h tdata=%0h", $time, m_axis_tuser_o,
                   m_axis_tdata_o);
        end else begin
          x = ring_results.pop_front();
          if ({x.st, x.free, x.total, x.wr, x.len, x.addr, x.idx, x.last} !==
              {m_axis_tuser_o, m_axis_tdata_o[145:0], m_axis_tlast_o}) begin
            errors++;
            $display("%0t: mismatch expected st=%0h idx=%0h addr=%0h len=%0h", $time,
                     x.st, x.idx, x.addr, x.len, " wr=%0b tot=%0h free=%0d last=%0b",
                     x.wr, x.total, x.free, x.last);
            $display("%0t:          actual st=%0h idx=%0h addr=%0h len=%0h", $time,
                     m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[71:8],
                     m_axis_tdata_o[103:72], " wr=%0b tot=%0h free=%0d last=%0b",
                     m_axis_tdata_o[104], m_axis_tdata_o[136:105],
                     m_axis_tdata_o[145:137], m_axis_tlast_o);
          end
        end
      end
      if (calm_mode) begin
        m_axis_tready_i <= 1'b1;
      end else if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 5) == 0) sink_stall = $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
